### rtl/ace_pkg.sv
// Shared types and constants of the ARP cache engine.
`default_nettype none
package ace_pkg;

	// Input item kinds.
	localparam logic [1:0] FN_RESOLVE = 2'd0;
	localparam logic [1:0] FN_LEARN   = 2'd1;
	localparam logic [1:0] FN_TICK    = 2'd2;

	// Result kinds.
	localparam logic [2:0] K_DONE = 3'd0;
	localparam logic [2:0] K_TX   = 3'd1;
	localparam logic [2:0] K_REL  = 3'd2;
	localparam logic [2:0] K_REQ  = 3'd3;
	localparam logic [2:0] K_REP  = 3'd4;

	// Done status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ARP  = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;

	// Classified command codes handed from front to back.
	localparam logic [2:0] OP_NOP       = 3'd0;
	localparam logic [2:0] OP_DIRECT    = 3'd1;
	localparam logic [2:0] OP_RESOLVE   = 3'd2;
	localparam logic [2:0] OP_LEARN     = 3'd3;
	localparam logic [2:0] OP_LEARN_BAD = 3'd4;
	localparam logic [2:0] OP_TICK      = 3'd5;

	// ARP header constants.
	localparam logic [15:0] ARP_HW_ETHER  = 16'h0001;
	localparam logic [15:0] ARP_PROTO_IP4 = 16'h0800;
	localparam logic [7:0]  ARP_HW_LEN    = 8'd6;
	localparam logic [7:0]  ARP_PROTO_LEN = 8'd4;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;
	localparam logic [10:0] ARP_MIN_LEN   = 11'd28;
	localparam logic [7:0]  MCAST_LO      = 8'd224;
	localparam logic [7:0]  MCAST_HI      = 8'd239;
	localparam logic [23:0] MCAST_OUI     = 24'h01005E;

	// Configuration register indexes.
	localparam logic [1:0] REG_LOCAL_IP = 2'd0;
	localparam logic [1:0] REG_LIFETIME = 2'd1;
	localparam logic [1:0] REG_RETRY    = 2'd2;
	localparam logic [1:0] REG_MAX_RTY  = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now;
		logic [31:0] ip_addr;
		logic [47:0] sender_mac;
		logic [7:0]  packet_handle;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] arp_oper;
		logic [31:0] tgt_ip_addr;
		logic [10:0] frame_length;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_handle;
		logic [47:0] dest_mac;
		logic [31:0] dest_ip;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  handle;
		logic [31:0] tgt_ip_addr;
		logic        is_req;
	} cmd_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [30:0] lifetime;
		logic [30:0] retry_interval;
		logic [7:0]  max_retries;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/ace_front.sv
// Front part: accepts input items, classifies them and queues commands.
`default_nettype none
module ace_front
	import ace_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_pop
);

	cmd_t       cls;
	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       wr;
	logic       rd;
	logic       hdr_ok;
	logic [7:0] top;

	// Classification of the incoming item.
	always_comb begin
		top    = item.ip_addr[31:24];
		hdr_ok = (item.frame_length >= ARP_MIN_LEN) && (item.hw_type == ARP_HW_ETHER) &&
			(item.proto_type == ARP_PROTO_IP4) && (item.hw_len == ARP_HW_LEN) &&
			(item.proto_len == ARP_PROTO_LEN);
		cls             = '0;
		cls.now         = item.now;
		cls.ip          = item.ip_addr;
		cls.mac         = item.sender_mac;
		cls.handle      = item.packet_handle;
		cls.tgt_ip_addr = item.tgt_ip_addr;
		cls.is_req      = (item.arp_oper == ARP_OP_REQ);
		unique case (item.func)
			FN_RESOLVE: begin
				if (item.ip_addr == '1) begin
					cls.op  = OP_DIRECT;
					cls.mac = '1;
				end else if (top >= MCAST_LO && top <= MCAST_HI) begin
					cls.op  = OP_DIRECT;
					cls.mac = {MCAST_OUI, 1'b0, item.ip_addr[22:0]};
				end else begin
					cls.op = OP_RESOLVE;
				end
			end
			FN_LEARN: cls.op = hdr_ok ? OP_LEARN : OP_LEARN_BAD;
			FN_TICK:  cls.op = OP_TICK;
			default:  cls.op = OP_NOP;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = mem_q[rptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;

	// Two-entry command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) wptr_q <= !wptr_q;
			if (rd) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= cls;
	end

endmodule
`default_nettype wire

### rtl/ace_outq.sv
// Two-entry result queue feeding the output side.
`default_nettype none
module ace_outq
	import ace_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire result_t wdata,
	output logic         full,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	result_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       we;
	logic       re;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign result = mem_q[rptr_q];
	assign we     = wr && !full;
	assign re     = pop && !empty;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (we) wptr_q <= !wptr_q;
			if (re) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(we) - 2'(re);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wptr_q] <= wdata;
	end

endmodule
`default_nettype wire

### rtl/ace_back.sv
// Back part: walks the neighbour table and produces result beats.
`default_nettype none
module ace_back
	import ace_pkg::*;
#(
	parameter int CACHE_ENTRIES = 8,
	parameter int HANDLE_BITS   = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	output logic       opush,
	output result_t    obeat,
	input  wire logic  ofull
);

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

	localparam logic [1:0] E_FREE = 2'd0;
	localparam logic [1:0] E_PEND = 2'd1;
	localparam logic [1:0] E_RES  = 2'd2;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_EVICT  = 3'd3;
	localparam logic [2:0] S_MAIN   = 3'd4;
	localparam logic [2:0] S_REPLY  = 3'd5;
	localparam logic [2:0] S_TICK   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	localparam logic [1:0] M_HIT   = 2'd0;
	localparam logic [1:0] M_FOUND = 2'd1;
	localparam logic [1:0] M_ALLOC = 2'd2;
	localparam logic [1:0] M_NONE  = 2'd3;

	localparam logic [31:0] SIGN = 32'h8000_0000;

	// Neighbour table.
	logic [1:0]             st_tab_q  [CACHE_ENTRIES];
	logic [31:0]            ip_tab_q  [CACHE_ENTRIES];
	logic [47:0]            mac_tab_q [CACHE_ENTRIES];
	logic [31:0]            exp_tab_q [CACHE_ENTRIES];
	logic [31:0]            rty_tab_q [CACHE_ENTRIES];
	logic [7:0]             rr_tab_q  [CACHE_ENTRIES];
	logic [HANDLE_BITS-1:0] ph_tab_q  [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] pv_q;

	logic [2:0]  st_q;
	cmd_t        cmd_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] tgt_q;
	logic [1:0]  mode_q;
	logic        vfree_q;
	logic [1:0]  status_q;

	// Scan findings.
	logic          hit_f_q, fnd_f_q, free_f_q, res_f_q, pen_f_q;
	logic [IW-1:0] hit_i_q, fnd_i_q, free_i_q, res_i_q, pen_i_q;
	logic [31:0]   res_v_q, pen_v_q;

	logic [IW-1:0]          rd_idx;
	logic [1:0]             rd_st;
	logic [31:0]            rd_ip;
	logic [47:0]            rd_mac;
	logic [31:0]            rd_exp;
	logic [31:0]            rd_rty;
	logic [7:0]             rd_rr;
	logic                   rd_pv;
	logic [HANDLE_BITS-1:0] rd_ph;
	logic [HANDLE_BITS-1:0] hnd;
	logic [31:0]            v_res;
	logic [31:0]            v_pen;
	logic                   ip_eq;
	logic                   rty_due;
	logic                   exp_due;
	logic                   emit;
	logic                   adv;
	logic                   is_learn;

	// Single read port of the table.
	always_comb begin
		rd_idx = (st_q == S_SCAN || st_q == S_TICK) ? cnt_q : tgt_q;
		rd_st  = st_tab_q[rd_idx];
		rd_ip  = ip_tab_q[rd_idx];
		rd_mac = mac_tab_q[rd_idx];
		rd_exp = exp_tab_q[rd_idx];
		rd_rty = rty_tab_q[rd_idx];
		rd_rr  = rr_tab_q[rd_idx];
		rd_pv  = pv_q[rd_idx];
		rd_ph  = ph_tab_q[rd_idx];
	end

	// Deadline arithmetic for the entry under the read port.
	always_comb begin
		hnd      = HANDLE_BITS'(cmd_q.handle);
		is_learn = (cmd_q.op == OP_LEARN);
		ip_eq    = (rd_ip == cmd_q.ip);
		v_res    = (rd_exp - cmd_q.now) ^ SIGN;
		v_pen    = (rd_rty - cmd_q.now) ^ SIGN;
		rty_due  = ((cmd_q.now - rd_rty) & SIGN) == '0;
		exp_due  = ((cmd_q.now - rd_exp) & SIGN) == '0;
	end

	// Result beat selection for the current step.
	always_comb begin
		emit  = 1'b0;
		obeat = '0;
		unique case (st_q)
			S_EVICT: begin
				obeat.kind       = K_REL;
				obeat.out_handle = 8'(rd_ph);
				emit = rd_pv && ((!is_learn && mode_q == M_FOUND) ||
					(mode_q == M_ALLOC && !vfree_q));
			end
			S_MAIN: begin
				if (cmd_q.op == OP_DIRECT) begin
					emit             = 1'b1;
					obeat.kind       = K_TX;
					obeat.out_handle = 8'(hnd);
					obeat.dest_mac   = cmd_q.mac;
				end else if (is_learn) begin
					emit             = (mode_q == M_FOUND) && rd_pv;
					obeat.kind       = K_TX;
					obeat.out_handle = 8'(rd_ph);
					obeat.dest_mac   = cmd_q.mac;
				end else begin
					case (mode_q)
						M_HIT: begin
							emit             = 1'b1;
							obeat.kind       = K_TX;
							obeat.out_handle = 8'(hnd);
							obeat.dest_mac   = rd_mac;
						end
						M_NONE: begin
							emit             = 1'b1;
							obeat.kind       = K_REL;
							obeat.out_handle = 8'(hnd);
						end
						M_ALLOC: begin
							emit          = 1'b1;
							obeat.kind    = K_REQ;
							obeat.dest_ip = cmd_q.ip;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			S_REPLY: begin
				emit           = cmd_q.is_req;
				obeat.kind     = K_REP;
				obeat.dest_mac = cmd_q.mac;
				obeat.dest_ip  = cmd_q.ip;
			end
			S_TICK: begin
				if (rd_st == E_PEND && rty_due) begin
					if (rd_rr != 8'd0) begin
						emit          = 1'b1;
						obeat.kind    = K_REQ;
						obeat.dest_ip = rd_ip;
					end else begin
						emit             = rd_pv;
						obeat.kind       = K_REL;
						obeat.out_handle = 8'(rd_ph);
					end
				end
			end
			S_DONE: begin
				emit         = 1'b1;
				obeat.kind   = K_DONE;
				obeat.status = status_q;
				obeat.last   = 1'b1;
			end
			default: emit = 1'b0;
		endcase
		adv     = !emit || !ofull;
		opush   = emit && !ofull;
		cmd_pop = (st_q == S_IDLE) && cmd_valid;
	end

	// Sequencer and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_DIRECT:  st_q <= S_MAIN;
							OP_RESOLVE: st_q <= S_SCAN;
							OP_LEARN:   st_q <= (cmd.tgt_ip_addr == cfg.local_ip) ?
								S_SCAN : S_DONE;
							OP_TICK:    st_q <= S_TICK;
							default:    st_q <= S_DONE;
						endcase
					end
				end
				S_SCAN:   if (cnt_q == LAST_IDX) st_q <= S_DECIDE;
				S_DECIDE: st_q <= S_EVICT;
				S_EVICT:  if (adv) st_q <= S_MAIN;
				S_MAIN:   if (adv) st_q <= is_learn ? S_REPLY : S_DONE;
				S_REPLY:  if (adv) st_q <= S_DONE;
				S_TICK:   if (adv && cnt_q == LAST_IDX) st_q <= S_DONE;
				S_DONE:   if (adv) st_q <= S_IDLE;
				default:  st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				cmd_q    <= cmd;
				cnt_q    <= '0;
				hit_f_q  <= 1'b0;
				fnd_f_q  <= 1'b0;
				free_f_q <= 1'b0;
				res_f_q  <= 1'b0;
				pen_f_q  <= 1'b0;
				status_q <= (cmd.op == OP_LEARN_BAD) ? ST_BAD_ARP : ST_OK;
			end
			S_SCAN: begin
				cnt_q <= cnt_q + 1'b1;
				if (rd_st != E_FREE && ip_eq && !fnd_f_q) begin
					fnd_f_q <= 1'b1;
					fnd_i_q <= cnt_q;
				end
				if (rd_st == E_RES && ip_eq && !hit_f_q) begin
					hit_f_q <= 1'b1;
					hit_i_q <= cnt_q;
				end
				if (rd_st == E_FREE && !free_f_q) begin
					free_f_q <= 1'b1;
					free_i_q <= cnt_q;
				end
				if (rd_st == E_RES && (!res_f_q || v_res < res_v_q)) begin
					res_f_q <= 1'b1;
					res_i_q <= cnt_q;
					res_v_q <= v_res;
				end
				if (rd_st == E_PEND && (!pen_f_q || v_pen < pen_v_q)) begin
					pen_f_q <= 1'b1;
					pen_i_q <= cnt_q;
					pen_v_q <= v_pen;
				end
			end
			S_DECIDE: begin
				vfree_q <= free_f_q;
				if (!is_learn && hit_f_q) begin
					mode_q <= M_HIT;
					tgt_q  <= hit_i_q;
				end else if (fnd_f_q) begin
					mode_q <= M_FOUND;
					tgt_q  <= fnd_i_q;
				end else if (free_f_q) begin
					mode_q <= M_ALLOC;
					tgt_q  <= free_i_q;
				end else if (res_f_q) begin
					mode_q <= M_ALLOC;
					tgt_q  <= res_i_q;
				end else if (pen_f_q) begin
					mode_q <= M_ALLOC;
					tgt_q  <= pen_i_q;
				end else begin
					mode_q <= M_NONE;
					if (!is_learn) status_q <= ST_NO_ENTRY;
				end
			end
			S_TICK: if (adv) cnt_q <= cnt_q + 1'b1;
			default: ;
		endcase
	end

	// Table state with reset: entry state and parked flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) st_tab_q[i] <= E_FREE;
			pv_q <= '0;
		end else if (adv) begin
			if (st_q == S_MAIN && cmd_q.op != OP_DIRECT) begin
				if (is_learn && mode_q != M_NONE) begin
					st_tab_q[tgt_q] <= E_RES;
					pv_q[tgt_q]     <= 1'b0;
				end else if (!is_learn && mode_q == M_FOUND) begin
					pv_q[tgt_q] <= 1'b1;
				end else if (!is_learn && mode_q == M_ALLOC) begin
					st_tab_q[tgt_q] <= E_PEND;
					pv_q[tgt_q]     <= 1'b1;
				end
			end else if (st_q == S_TICK) begin
				if ((rd_st == E_PEND && rty_due && rd_rr == 8'd0) ||
					(rd_st == E_RES && exp_due)) begin
					st_tab_q[cnt_q] <= E_FREE;
					pv_q[cnt_q]     <= 1'b0;
				end
			end
		end
	end

	// Table payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (st_q == S_MAIN && cmd_q.op != OP_DIRECT) begin
				if (is_learn && mode_q != M_NONE) begin
					ip_tab_q[tgt_q]  <= cmd_q.ip;
					mac_tab_q[tgt_q] <= cmd_q.mac;
					exp_tab_q[tgt_q] <= cmd_q.now + {1'b0, cfg.lifetime};
				end else if (!is_learn && mode_q == M_FOUND) begin
					ph_tab_q[tgt_q] <= hnd;
				end else if (!is_learn && mode_q == M_ALLOC) begin
					ip_tab_q[tgt_q]  <= cmd_q.ip;
					exp_tab_q[tgt_q] <= cmd_q.now + {1'b0, cfg.lifetime};
					rty_tab_q[tgt_q] <= cmd_q.now + {1'b0, cfg.retry_interval};
					rr_tab_q[tgt_q]  <= cfg.max_retries;
					ph_tab_q[tgt_q]  <= hnd;
				end
			end else if (st_q == S_TICK) begin
				if (rd_st == E_PEND && rty_due && rd_rr != 8'd0) begin
					rr_tab_q[cnt_q]  <= rd_rr - 8'd1;
					rty_tab_q[cnt_q] <= cmd_q.now + {1'b0, cfg.retry_interval};
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(opush && obeat.last) |=> (st_q == S_IDLE))
		else $error("done beat did not return the sequencer to idle");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (st_q == S_IDLE))
		else $error("command taken while busy");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN || st_q == S_TICK) |-> (cnt_q <= LAST_IDX))
		else $error("walk index beyond table");
	a_last_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (obeat.last == (st_q == S_DONE)))
		else $error("last flag on a beat other than done");
`endif

endmodule
`default_nettype wire

### rtl/arp_cache_engine_top.sv
// Top level of the ARP cache engine: configuration registers and part wiring.
//
// Channel   Direction  Handshake          Payload
// item      in         push / full        item_t
// result    out        empty / pop        result_t
// config    in/out     APB psel/penable   pwdata / prdata
//
// A resolve that is not broadcast or multicast and a learn addressed to the local IP
// walk the table through its single read port, one entry a cycle; a tick walks it
// likewise, but holds on an entry whose beat meets a full result queue.
// Direct resolves, bad frames and foreign learns skip the walk.
// Reset clears all entries at once; no clearing pass is needed.
// A full result queue stalls the tick walk and every beat; the two-entry command queue
// accepts items meanwhile until it holds two.
`default_nettype none
module arp_cache_engine_top
	import ace_pkg::*;
#(
	parameter int CACHE_ENTRIES = 8,
	parameter int HANDLE_BITS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire item_t       item,
	output logic             empty,
	input  wire logic        pop,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t    cfg_q;
	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	logic    opush;
	result_t obeat;
	logic    ofull;

	assign pready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip       <= '0;
			cfg_q.lifetime       <= 31'd60000;
			cfg_q.retry_interval <= 31'd1000;
			cfg_q.max_retries    <= 8'd3;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_LOCAL_IP: cfg_q.local_ip       <= pwdata;
				REG_LIFETIME: cfg_q.lifetime       <= pwdata[30:0];
				REG_RETRY:    cfg_q.retry_interval <= pwdata[30:0];
				REG_MAX_RTY:  cfg_q.max_retries    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_LOCAL_IP: prdata = cfg_q.local_ip;
			REG_LIFETIME: prdata = {1'b0, cfg_q.lifetime};
			REG_RETRY:    prdata = {1'b0, cfg_q.retry_interval};
			REG_MAX_RTY:  prdata = {24'd0, cfg_q.max_retries};
			default:      prdata = '0;
		endcase
	end

	ace_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ace_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.HANDLE_BITS   (HANDLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.opush     (opush),
		.obeat     (obeat),
		.ofull     (ofull)
	);

	ace_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (opush),
		.wdata  (obeat),
		.full   (ofull),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
